/* sv/bagt_pkg.sv */
// Shared widths, coefficients, stage sideband type and the tanh lookup table.
package bagt_pkg;

    // Data format
    localparam int DATA_WIDTH   = 16;
    localparam int FRAC_BITS    = 12;
    localparam int TANH_ENTRIES = 256;

    // Magnitude path widths (valid while |z| < 4.0)
    localparam int MAG_W  = (DATA_WIDTH > FRAC_BITS + 3) ? DATA_WIDTH : FRAC_BITS + 3;
    localparam int M_W    = FRAC_BITS + 2;
    localparam int M2_W   = FRAC_BITS + 4;
    localparam int M3_W   = FRAC_BITS + 6;
    localparam int TERM_W = FRAC_BITS + 2;
    localparam int V_W    = FRAC_BITS + 3;
    localparam int U_W    = FRAC_BITS + 3;

    // tanh lookup widths
    localparam int TH_W   = FRAC_BITS + 1;
    localparam int FR_W   = FRAC_BITS + 2;
    localparam int IDX_W  = $clog2(TANH_ENTRIES + 1);
    localparam int P_W    = FR_W + IDX_W;
    localparam int ONEP_W = FRAC_BITS + 2;

    // Final product width
    localparam int PROD_W = DATA_WIDTH + ONEP_W + 1;

    // Q30 coefficients: 0.044715 and sqrt(2/pi)
    localparam int COEF_W = 30;
    localparam logic [COEF_W-1:0] COEF_CUBE  = COEF_W'(48012366);
    localparam logic [COEF_W-1:0] COEF_SCALE = COEF_W'(856722024);

    localparam logic signed [DATA_WIDTH-1:0] DATA_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam logic signed [DATA_WIDTH-1:0] DATA_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    // Sideband that rides along the add, polynomial and tanh stages
    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] z;
        logic                         sat;
        logic                         big;
    } side_t;

    typedef logic [TH_W-1:0] tanh_tab_t [TANH_ENTRIES+1];

    localparam logic [63:0] Q60 = 64'd1 << 60;

    // floor(a*b / 2^60) from 30-bit halves
    function automatic logic [63:0] mul60(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] ah;
        logic [63:0] al;
        logic [63:0] bh;
        logic [63:0] bl;
        logic [63:0] mid;
        ah  = a >> 30;
        al  = a & 64'h3FFF_FFFF;
        bh  = b >> 30;
        bl  = b & 64'h3FFF_FFFF;
        mid = ah * bl + al * bh + ((al * bl) >> 30);
        return ah * bh + (mid >> 30);
    endfunction

    // Shift-subtract quotient, only evaluated while the constant table is built
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--)
        begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Table of round(2^F * tanh(4k/N)), exact integer evaluation of exp(-2x)
    function automatic tanh_tab_t build_tanh_tab();
        tanh_tab_t   tab;
        logic [63:0] y;
        logic [63:0] acc;
        logic [63:0] a;
        logic [63:0] b;
        for (int k = 0; k <= TANH_ENTRIES; k++)
        begin
            y   = udiv64(64'(k) << 50, 64'(TANH_ENTRIES)) << 5;
            acc = Q60;
            for (int n = 12; n >= 1; n--)
            begin
                acc = Q60 - udiv64(mul60(y, acc), 64'(n));
            end
            for (int s = 0; s < 8; s++)
            begin
                acc = mul60(acc, acc);
            end
            a      = (Q60 - acc) >> 30;
            b      = (Q60 + acc) >> 30;
            tab[k] = TH_W'(udiv64(a * (64'd1 << (FRAC_BITS + 1)) + b, 64'd2 * b));
        end
        return tab;
    endfunction

    localparam tanh_tab_t TANH_TAB = build_tanh_tab();

endpackage

/* sv/bias_add_gelu_tanh.sv */
// Top level: bias add with saturation followed by tanh-approximated GeLU.
//
// Usage:
//   Input channel (in_valid/in_ready) carries act_value and bias_value, both
//   signed Q3.12. A transfer happens on a rising edge with valid and ready high.
//   Output channel (out_valid/out_ready) carries gelu_value (signed Q3.12,
//   rounded to nearest) and sum_saturated, set when act_value + bias_value
//   was clipped to the 16-bit range.
//   Nine register stages: one for the saturating add, four for the polynomial
//   (square, cube, cubic correction, scaling), two for the tanh table lookup
//   and interpolation, two for the final multiply and rounding. Throughput is
//   one item per cycle while out_ready stays high. When the receiver stalls,
//   each stage keeps its item and keeps accepting until the pipeline is full;
//   in_ready drops only when all stages are full. Asynchronous active-low
//   reset empties every stage. The tanh table is a constant, so the block is
//   ready as soon as reset is released.
module bias_add_gelu_tanh (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic signed [bagt_pkg::DATA_WIDTH-1:0]  act_value,
    input  logic signed [bagt_pkg::DATA_WIDTH-1:0]  bias_value,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    output logic signed [bagt_pkg::DATA_WIDTH-1:0]  gelu_value,
    output logic                                    sum_saturated,
    output logic                                    out_valid,
    input  logic                                    out_ready
);

    bagt_pkg::side_t                   add_side;
    logic                              add_valid;
    logic                              add_ready;
    bagt_pkg::side_t                   poly_side;
    logic [bagt_pkg::U_W-1:0]          poly_u;
    logic                              poly_valid;
    logic                              poly_ready;
    bagt_pkg::side_t                   tanh_side;
    logic [bagt_pkg::ONEP_W-1:0]       tanh_onep;
    logic                              tanh_valid;
    logic                              tanh_ready;

    // Saturating add
    bagt_add_sat u_add_sat (
        .clk        (clk),
        .rst_n      (rst_n),
        .act_value  (act_value),
        .bias_value (bias_value),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .side       (add_side),
        .side_valid (add_valid),
        .side_ready (add_ready)
    );

    // Polynomial argument of tanh
    bagt_poly u_poly (
        .clk       (clk),
        .rst_n     (rst_n),
        .side_in   (add_side),
        .in_valid  (add_valid),
        .in_ready  (add_ready),
        .side_out  (poly_side),
        .u_out     (poly_u),
        .out_valid (poly_valid),
        .out_ready (poly_ready)
    );

    // tanh lookup
    bagt_tanh u_tanh (
        .clk       (clk),
        .rst_n     (rst_n),
        .side_in   (poly_side),
        .u_in      (poly_u),
        .in_valid  (poly_valid),
        .in_ready  (poly_ready),
        .side_out  (tanh_side),
        .onep_out  (tanh_onep),
        .out_valid (tanh_valid),
        .out_ready (tanh_ready)
    );

    // Final product and output register
    bagt_out u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .side_in       (tanh_side),
        .onep_in       (tanh_onep),
        .in_valid      (tanh_valid),
        .in_ready      (tanh_ready),
        .gelu_value    (gelu_value),
        .sum_saturated (sum_saturated),
        .out_valid     (out_valid),
        .out_ready     (out_ready)
    );

endmodule

/* sv/bagt_add_sat.sv */
// First stage: activation plus bias with saturation to the data width.
module bagt_add_sat (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic signed [bagt_pkg::DATA_WIDTH-1:0]  act_value,
    input  logic signed [bagt_pkg::DATA_WIDTH-1:0]  bias_value,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    output bagt_pkg::side_t                         side,
    output logic                                    side_valid,
    input  logic                                    side_ready
);

    logic                                  valid_reg;
    bagt_pkg::side_t                       side_reg;
    bagt_pkg::side_t                       side_next;
    logic signed [bagt_pkg::DATA_WIDTH:0]  sum_w;

    assign in_ready   = !valid_reg || side_ready;
    assign side       = side_reg;
    assign side_valid = valid_reg;

    // Wide add, clip on overflow of the top bit
    always_comb
    begin
        sum_w = {act_value[bagt_pkg::DATA_WIDTH-1], act_value}
              + {bias_value[bagt_pkg::DATA_WIDTH-1], bias_value};
        side_next.big = 1'b0;
        side_next.sat = sum_w[bagt_pkg::DATA_WIDTH] ^ sum_w[bagt_pkg::DATA_WIDTH-1];
        if (side_next.sat)
        begin
            side_next.z = sum_w[bagt_pkg::DATA_WIDTH] ? bagt_pkg::DATA_MIN
                                                      : bagt_pkg::DATA_MAX;
        end
        else
        begin
            side_next.z = sum_w[bagt_pkg::DATA_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            side_reg <= side_next;
        end
    end

`ifndef SYNTHESIS
    // A clipped sum always sits on one of the two rails
    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && side_reg.sat |->
            (side_reg.z == bagt_pkg::DATA_MAX) || (side_reg.z == bagt_pkg::DATA_MIN))
        else $error("saturated sum not on a rail");
`endif

endmodule

/* sv/bagt_poly.sv */
// Stages two to five: |z| and square, cube, cubic correction and scaling to the tanh argument.
module bagt_poly (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bagt_pkg::side_t               side_in,
    input  logic                          in_valid,
    output logic                          in_ready,
    output bagt_pkg::side_t               side_out,
    output logic [bagt_pkg::U_W-1:0]      u_out,
    output logic                          out_valid,
    input  logic                          out_ready
);

    // Stage registers
    logic                              p1_valid_reg;
    logic                              p2_valid_reg;
    logic                              p3_valid_reg;
    logic                              p4_valid_reg;
    bagt_pkg::side_t                   p1_side_reg;
    bagt_pkg::side_t                   p2_side_reg;
    bagt_pkg::side_t                   p3_side_reg;
    bagt_pkg::side_t                   p4_side_reg;
    logic [bagt_pkg::M_W-1:0]          p1_m_reg;
    logic [bagt_pkg::M_W-1:0]          p2_m_reg;
    logic [bagt_pkg::M2_W-1:0]         p1_m2_reg;
    logic [bagt_pkg::M3_W-1:0]         p2_m3_reg;
    logic [bagt_pkg::V_W-1:0]          p3_v_reg;
    logic [bagt_pkg::U_W-1:0]          p4_u_reg;

    // Next values
    bagt_pkg::side_t                   p1_side_next;
    logic [bagt_pkg::M_W-1:0]          p1_m_next;
    logic [bagt_pkg::M2_W-1:0]         p1_m2_next;
    logic [bagt_pkg::M3_W-1:0]         p2_m3_next;
    logic [bagt_pkg::V_W-1:0]          p3_v_next;
    logic [bagt_pkg::U_W-1:0]          p4_u_next;

    // Arithmetic temporaries
    logic signed [bagt_pkg::MAG_W:0]                    z_ext;
    logic signed [bagt_pkg::MAG_W:0]                    mag_s;
    logic [bagt_pkg::MAG_W-1:0]                         mag;
    logic [2*bagt_pkg::M_W-1:0]                         sq;
    logic [bagt_pkg::M2_W+bagt_pkg::M_W-1:0]            cube;
    logic [bagt_pkg::M3_W+bagt_pkg::COEF_W-1:0]         corr;
    logic [bagt_pkg::TERM_W-1:0]                        term;
    logic [bagt_pkg::V_W+bagt_pkg::COEF_W-1:0]          scaled;

    logic p1_ready;
    logic p2_ready;
    logic p3_ready;
    logic p4_ready;

    // Ready chain: a stage moves when it is empty or its successor takes it
    assign p4_ready = !p4_valid_reg || out_ready;
    assign p3_ready = !p3_valid_reg || p4_ready;
    assign p2_ready = !p2_valid_reg || p3_ready;
    assign p1_ready = !p1_valid_reg || p2_ready;
    assign in_ready = p1_ready;

    assign side_out  = p4_side_reg;
    assign u_out     = p4_u_reg;
    assign out_valid = p4_valid_reg;

    // Magnitude, large-argument flag and square
    always_comb
    begin
        z_ext = (bagt_pkg::MAG_W + 1)'(side_in.z);
        mag_s = z_ext[bagt_pkg::MAG_W] ? -z_ext : z_ext;
        mag   = mag_s[bagt_pkg::MAG_W-1:0];
        p1_side_next     = side_in;
        p1_side_next.big = mag >= bagt_pkg::MAG_W'(4 << bagt_pkg::FRAC_BITS);
        p1_m_next        = mag[bagt_pkg::M_W-1:0];
        sq = p1_m_next * p1_m_next
           + ((2*bagt_pkg::M_W)'(1) << (bagt_pkg::FRAC_BITS - 1));
        p1_m2_next = sq[bagt_pkg::FRAC_BITS +: bagt_pkg::M2_W];
    end

    // Cube
    always_comb
    begin
        cube = (bagt_pkg::M2_W + bagt_pkg::M_W)'(p1_m2_reg)
             * (bagt_pkg::M2_W + bagt_pkg::M_W)'(p1_m_reg)
             + ((bagt_pkg::M2_W + bagt_pkg::M_W)'(1) << (bagt_pkg::FRAC_BITS - 1));
        p2_m3_next = cube[bagt_pkg::FRAC_BITS +: bagt_pkg::M3_W];
    end

    // v = m + 0.044715 * m^3
    always_comb
    begin
        corr = (bagt_pkg::M3_W + bagt_pkg::COEF_W)'(p2_m3_reg)
             * (bagt_pkg::M3_W + bagt_pkg::COEF_W)'(bagt_pkg::COEF_CUBE)
             + ((bagt_pkg::M3_W + bagt_pkg::COEF_W)'(1) << 29);
        term      = corr[bagt_pkg::COEF_W +: bagt_pkg::TERM_W];
        p3_v_next = bagt_pkg::V_W'(p2_m_reg) + bagt_pkg::V_W'(term);
    end

    // u = sqrt(2/pi) * v
    always_comb
    begin
        scaled = (bagt_pkg::V_W + bagt_pkg::COEF_W)'(p3_v_reg)
               * (bagt_pkg::V_W + bagt_pkg::COEF_W)'(bagt_pkg::COEF_SCALE)
               + ((bagt_pkg::V_W + bagt_pkg::COEF_W)'(1) << 29);
        p4_u_next = scaled[bagt_pkg::COEF_W +: bagt_pkg::U_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
            p4_valid_reg <= 1'b0;
        end
        else
        begin
            if (p1_ready)
            begin
                p1_valid_reg <= in_valid;
            end
            if (p2_ready)
            begin
                p2_valid_reg <= p1_valid_reg;
            end
            if (p3_ready)
            begin
                p3_valid_reg <= p2_valid_reg;
            end
            if (p4_ready)
            begin
                p4_valid_reg <= p3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (p1_ready && in_valid)
        begin
            p1_side_reg <= p1_side_next;
            p1_m_reg    <= p1_m_next;
            p1_m2_reg   <= p1_m2_next;
        end
        if (p2_ready && p1_valid_reg)
        begin
            p2_side_reg <= p1_side_reg;
            p2_m_reg    <= p1_m_reg;
            p2_m3_reg   <= p2_m3_next;
        end
        if (p3_ready && p2_valid_reg)
        begin
            p3_side_reg <= p2_side_reg;
            p3_v_reg    <= p3_v_next;
        end
        if (p4_ready && p3_valid_reg)
        begin
            p4_side_reg <= p3_side_reg;
            p4_u_reg    <= p4_u_next;
        end
    end

endmodule

/* sv/bagt_tanh.sv */
// Stages six and seven: table lookup, linear interpolation and 1 +/- tanh.
module bagt_tanh (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bagt_pkg::side_t               side_in,
    input  logic [bagt_pkg::U_W-1:0]      u_in,
    input  logic                          in_valid,
    output logic                          in_ready,
    output bagt_pkg::side_t               side_out,
    output logic [bagt_pkg::ONEP_W-1:0]   onep_out,
    output logic                          out_valid,
    input  logic                          out_ready
);

    logic                              t1_valid_reg;
    logic                              t2_valid_reg;
    bagt_pkg::side_t                   t1_side_reg;
    bagt_pkg::side_t                   t2_side_reg;
    logic                              t1_one_reg;
    logic [bagt_pkg::TH_W-1:0]         t1_t0_reg;
    logic [bagt_pkg::TH_W-1:0]         t1_t1_reg;
    logic [bagt_pkg::FR_W-1:0]         t1_fr_reg;
    logic [bagt_pkg::ONEP_W-1:0]       t2_onep_reg;

    logic                              t1_one_next;
    logic [bagt_pkg::TH_W-1:0]         t1_t0_next;
    logic [bagt_pkg::TH_W-1:0]         t1_t1_next;
    logic [bagt_pkg::FR_W-1:0]         t1_fr_next;
    logic [bagt_pkg::ONEP_W-1:0]       t2_onep_next;

    logic [bagt_pkg::P_W-1:0]          pos;
    logic [bagt_pkg::IDX_W-1:0]        idx;
    logic [bagt_pkg::IDX_W-1:0]        idx_up;
    logic [bagt_pkg::TH_W-1:0]         diff;
    logic [bagt_pkg::TH_W+bagt_pkg::FR_W-1:0] interp_w;
    logic [bagt_pkg::TH_W-1:0]         th_pos;

    logic t1_ready;
    logic t2_ready;

    assign t2_ready = !t2_valid_reg || out_ready;
    assign t1_ready = !t1_valid_reg || t2_ready;
    assign in_ready = t1_ready;

    assign side_out  = t2_side_reg;
    assign onep_out  = t2_onep_reg;
    assign out_valid = t2_valid_reg;

    // Table address from u*N; low bits of u keep the index inside the table
    always_comb
    begin
        t1_one_next = side_in.big || (u_in >= bagt_pkg::U_W'(4 << bagt_pkg::FRAC_BITS));
        pos         = bagt_pkg::P_W'(u_in[bagt_pkg::FR_W-1:0])
                    * bagt_pkg::P_W'(bagt_pkg::TANH_ENTRIES);
        idx         = pos[bagt_pkg::FR_W +: bagt_pkg::IDX_W];
        idx_up      = idx + bagt_pkg::IDX_W'(1);
        t1_fr_next  = pos[bagt_pkg::FR_W-1:0];
        t1_t0_next  = bagt_pkg::TANH_TAB[idx];
        t1_t1_next  = bagt_pkg::TANH_TAB[idx_up];
    end

    // Interpolate, then form 1 + tanh with the sign of z
    always_comb
    begin
        diff     = (t1_t1_reg >= t1_t0_reg) ? (t1_t1_reg - t1_t0_reg) : '0;
        interp_w = (bagt_pkg::TH_W + bagt_pkg::FR_W)'(diff)
                 * (bagt_pkg::TH_W + bagt_pkg::FR_W)'(t1_fr_reg)
                 + ((bagt_pkg::TH_W + bagt_pkg::FR_W)'(1) << (bagt_pkg::FRAC_BITS + 1));
        if (t1_one_reg)
        begin
            th_pos = bagt_pkg::TH_W'(1) << bagt_pkg::FRAC_BITS;
        end
        else
        begin
            th_pos = t1_t0_reg + interp_w[bagt_pkg::FR_W +: bagt_pkg::TH_W];
        end
        if (t1_side_reg.z[bagt_pkg::DATA_WIDTH-1])
        begin
            t2_onep_next = (bagt_pkg::ONEP_W'(1) << bagt_pkg::FRAC_BITS)
                         - bagt_pkg::ONEP_W'(th_pos);
        end
        else
        begin
            t2_onep_next = (bagt_pkg::ONEP_W'(1) << bagt_pkg::FRAC_BITS)
                         + bagt_pkg::ONEP_W'(th_pos);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_valid_reg <= 1'b0;
            t2_valid_reg <= 1'b0;
        end
        else
        begin
            if (t1_ready)
            begin
                t1_valid_reg <= in_valid;
            end
            if (t2_ready)
            begin
                t2_valid_reg <= t1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (t1_ready && in_valid)
        begin
            t1_side_reg <= side_in;
            t1_one_reg  <= t1_one_next;
            t1_t0_reg   <= t1_t0_next;
            t1_t1_reg   <= t1_t1_next;
            t1_fr_reg   <= t1_fr_next;
        end
        if (t2_ready && t1_valid_reg)
        begin
            t2_side_reg <= t1_side_reg;
            t2_onep_reg <= t2_onep_next;
        end
    end

`ifndef SYNTHESIS
    // 1 + tanh stays within [0, 2]
    a_onep_range: assert property (@(posedge clk) disable iff (!rst_n)
        t2_valid_reg |->
            t2_onep_reg <= (bagt_pkg::ONEP_W'(1) << (bagt_pkg::FRAC_BITS + 1)))
        else $error("1+tanh out of range");
`endif

endmodule

/* sv/bagt_out.sv */
// Stages eight and nine: z*(1+tanh), round, clamp and output register.
module bagt_out (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  bagt_pkg::side_t                         side_in,
    input  logic [bagt_pkg::ONEP_W-1:0]             onep_in,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    output logic signed [bagt_pkg::DATA_WIDTH-1:0]  gelu_value,
    output logic                                    sum_saturated,
    output logic                                    out_valid,
    input  logic                                    out_ready
);

    logic                                       o1_valid_reg;
    logic                                       o2_valid_reg;
    logic                                       o1_sat_reg;
    logic signed [bagt_pkg::PROD_W-1:0]         o1_prod_reg;
    logic signed [bagt_pkg::DATA_WIDTH-1:0]     o2_gelu_reg;
    logic                                       o2_sat_reg;

    logic signed [bagt_pkg::PROD_W-1:0]         o1_prod_next;
    logic signed [bagt_pkg::DATA_WIDTH-1:0]     o2_gelu_next;
    logic signed [bagt_pkg::PROD_W-1:0]         rounded;
    logic signed [bagt_pkg::PROD_W-1:0]         y_wide;

    logic o1_ready;
    logic o2_ready;

    assign o2_ready = !o2_valid_reg || out_ready;
    assign o1_ready = !o1_valid_reg || o2_ready;
    assign in_ready = o1_ready;

    assign gelu_value    = o2_gelu_reg;
    assign sum_saturated = o2_sat_reg;
    assign out_valid     = o2_valid_reg;

    // Signed product z * (1 + tanh)
    always_comb
    begin
        o1_prod_next = bagt_pkg::PROD_W'(side_in.z)
                     * bagt_pkg::PROD_W'(signed'({1'b0, onep_in}));
    end

    // Half, floor shift, clamp to the data range
    always_comb
    begin
        rounded = o1_prod_reg + (bagt_pkg::PROD_W'(1) <<< bagt_pkg::FRAC_BITS);
        y_wide  = rounded >>> (bagt_pkg::FRAC_BITS + 1);
        if (y_wide > bagt_pkg::PROD_W'(bagt_pkg::DATA_MAX))
        begin
            o2_gelu_next = bagt_pkg::DATA_MAX;
        end
        else if (y_wide < bagt_pkg::PROD_W'(bagt_pkg::DATA_MIN))
        begin
            o2_gelu_next = bagt_pkg::DATA_MIN;
        end
        else
        begin
            o2_gelu_next = y_wide[bagt_pkg::DATA_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            o1_valid_reg <= 1'b0;
            o2_valid_reg <= 1'b0;
        end
        else
        begin
            if (o1_ready)
            begin
                o1_valid_reg <= in_valid;
            end
            if (o2_ready)
            begin
                o2_valid_reg <= o1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (o1_ready && in_valid)
        begin
            o1_prod_reg <= o1_prod_next;
            o1_sat_reg  <= side_in.sat;
        end
        if (o2_ready && o1_valid_reg)
        begin
            o2_gelu_reg <= o2_gelu_next;
            o2_sat_reg  <= o1_sat_reg;
        end
    end

`ifndef SYNTHESIS
    // A clipped input is far outside the tanh range: result is z or zero
    a_sat_result: assert property (@(posedge clk) disable iff (!rst_n)
        o2_valid_reg && o2_sat_reg |->
            (o2_gelu_reg == bagt_pkg::DATA_MAX) || (o2_gelu_reg == '0))
        else $error("saturated input gave unexpected result");
`endif

endmodule

/* verif/tb_bias_add_gelu_tanh.sv */
// Self-checking testbench for the bias-add plus tanh-approximated GeLU pipeline.
module tb_bias_add_gelu_tanh;

    localparam int DW    = bagt_pkg::DATA_WIDTH;
    localparam int FB    = bagt_pkg::FRAC_BITS;
    localparam int LUT_N = bagt_pkg::TANH_ENTRIES;

    // Fixed-point constants of the GeLU datapath
    localparam longint Q_ONE       = longint'(1) <<< FB;
    localparam longint Q_HALF      = longint'(1) <<< (FB - 1);
    localparam longint Q30_HALF    = longint'(1) <<< 29;
    localparam longint CUBIC_Q30   = 48012366;
    localparam longint SQRT2PI_Q30 = 856722024;
    localparam longint SUM_MAX     = (longint'(1) <<< (DW - 1)) - 1;
    localparam longint SUM_MIN     = -SUM_MAX - 1;

    localparam int PIPE_DEPTH  = 9;
    localparam int IDLE_LIMIT  = 2000;
    localparam int REPORT_MAX  = 10;

    typedef struct {
        logic signed [DW-1:0] act;
        logic signed [DW-1:0] bias;
        logic signed [DW-1:0] gelu;
        logic                 sat;
    } gelu_result_t;

    logic                 clk        = 1'b0;
    logic                 rst_n      = 1'b0;
    logic signed [DW-1:0] act_value  = '0;
    logic signed [DW-1:0] bias_value = '0;
    logic                 in_valid   = 1'b0;
    logic                 in_ready;
    logic signed [DW-1:0] gelu_value;
    logic                 sum_saturated;
    logic                 out_valid;
    logic                 out_ready  = 1'b0;

    int           tanh_lut [0:LUT_N];
    gelu_result_t pending_gelu [$];
    gelu_result_t head_res;

    bit src_idle_en  = 1'b1;
    bit sink_idle_en = 1'b1;
    int sink_stall_left = 0;
    int idle_cycles     = 0;
    int fail_count      = 0;
    int items_sent      = 0;
    int results_checked = 0;
    int sat_results     = 0;
    int drain_pauses    = 0;

    bias_add_gelu_tanh dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .act_value     (act_value),
        .bias_value    (bias_value),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .gelu_value    (gelu_value),
        .sum_saturated (sum_saturated),
        .out_valid     (out_valid),
        .out_ready     (out_ready)
    );

    // 10-unit clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // floor(a*b / 2^60), exact through a 128-bit product
    function automatic logic [63:0] q60_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = 128'(a) * 128'(b);
        return prod[123:60];
    endfunction

    // tanh(4k/N) in Q.FB: exp(-2x) by a Taylor series on x/128, squared 8 times
    function automatic void fill_tanh_lut();
        logic [63:0] one_q60;
        logic [63:0] x;
        logic [63:0] e;
        logic [63:0] num;
        logic [63:0] den;
        one_q60 = 64'd1 << 60;
        for (int k = 0; k <= LUT_N; k++)
        begin
            x = ((64'(k) << 50) / 64'(LUT_N)) << 5;
            e = one_q60;
            for (int n = 12; n >= 1; n--)
            begin
                e = one_q60 - q60_mul(x, e) / 64'(n);
            end
            for (int s = 0; s < 8; s++)
            begin
                e = q60_mul(e, e);
            end
            num = (one_q60 - e) >> 30;
            den = (one_q60 + e) >> 30;
            tanh_lut[k] = int'((num * (64'd1 << (FB + 1)) + den) / (64'd2 * den));
        end
    endfunction

    // Expected GeLU and clip flag for one activation/bias pair
    function automatic gelu_result_t predict_gelu(input logic signed [DW-1:0] act,
                                                  input logic signed [DW-1:0] bias);
        gelu_result_t r;
        longint z;
        longint m;
        longint m2;
        longint m3;
        longint v;
        longint u;
        longint p;
        longint idx;
        longint fr;
        longint d;
        longint th;
        longint y;
        r.act  = act;
        r.bias = bias;
        r.sat  = 1'b0;
        z = longint'(act) + longint'(bias);
        if (z > SUM_MAX)
        begin
            z     = SUM_MAX;
            r.sat = 1'b1;
        end
        if (z < SUM_MIN)
        begin
            z     = SUM_MIN;
            r.sat = 1'b1;
        end
        // odd part on the magnitude, mirrored afterwards
        m = (z < 0) ? -z : z;
        if (m >= (longint'(4) <<< FB))
            th = Q_ONE;
        else
        begin
            m2 = (m * m + Q_HALF) >>> FB;
            m3 = (m2 * m + Q_HALF) >>> FB;
            v  = m + ((m3 * CUBIC_Q30 + Q30_HALF) >>> 30);
            u  = (v * SQRT2PI_Q30 + Q30_HALF) >>> 30;
            if (u >= (longint'(4) <<< FB))
                th = Q_ONE;
            else
            begin
                p   = u * LUT_N;
                idx = p >>> (FB + 2);
                fr  = p & ((longint'(1) <<< (FB + 2)) - 1);
                if (idx >= LUT_N)
                    th = tanh_lut[LUT_N];
                else
                begin
                    d = tanh_lut[idx + 1] - tanh_lut[idx];
                    if (d < 0)
                        d = 0;
                    th = tanh_lut[idx] + ((d * fr + (longint'(1) <<< (FB + 1))) >>> (FB + 2));
                end
            end
        end
        if (z < 0)
            th = -th;
        // arithmetic shift of a signed value is a floor division
        y = (z * (Q_ONE + th) + Q_ONE) >>> (FB + 1);
        if (y > SUM_MAX)
            y = SUM_MAX;
        if (y < SUM_MIN)
            y = SUM_MIN;
        r.gelu = y[DW-1:0];
        return r;
    endfunction

    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("[%0t] %s", $time, msg);
    endfunction

    // One input transfer, with an optional idle burst ahead of it
    task automatic send_pair(input logic signed [DW-1:0] act, input logic signed [DW-1:0] bias);
        int gap;
        if (src_idle_en && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 11);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        act_value  <= act;
        bias_value <= bias;
        in_valid   <= 1'b1;
        do @(posedge clk); while (!in_ready);
        pending_gelu.push_back(predict_gelu(act, bias));
        items_sent++;
    endtask

    // Sender holds off until every expected result has come back
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (pending_gelu.size() != 0)
            @(posedge clk);
    endtask

    // Random split of a target sum z into two in-range operands
    function automatic void split_sum(input int z, output logic signed [DW-1:0] a,
                                      output logic signed [DW-1:0] b);
        int lo;
        int hi;
        int a_i;
        lo  = (z - int'(SUM_MAX) > int'(SUM_MIN)) ? z - int'(SUM_MAX) : int'(SUM_MIN);
        hi  = (z - int'(SUM_MIN) < int'(SUM_MAX)) ? z - int'(SUM_MIN) : int'(SUM_MAX);
        a_i = lo + int'($urandom_range(0, hi - lo));
        a   = DW'(a_i);
        b   = DW'(z - a_i);
    endfunction

    // Mix: tanh region, full range, near clipping, tanh knee and zero
    task automatic pick_random_pair(output logic signed [DW-1:0] a,
                                    output logic signed [DW-1:0] b);
        int kind;
        int z;
        int a_i;
        int b_i;
        kind = $urandom_range(0, 9);
        if (kind <= 3)
        begin
            z = int'($urandom_range(0, 32767)) - 16384;
            split_sum(z, a, b);
        end
        else if (kind <= 6)
        begin
            a = DW'($urandom);
            b = DW'($urandom);
        end
        else if (kind <= 8)
        begin
            a_i = 32767 - int'($urandom_range(0, 511));
            b_i = int'($urandom_range(0, 1023)) - 256;
            if ($urandom_range(0, 1) == 1)
            begin
                a_i = -a_i - 1;
                b_i = -b_i;
            end
            a = DW'(a_i);
            b = DW'(b_i);
        end
        else
        begin
            if ($urandom_range(0, 1) == 1)
                z = 13709 + int'($urandom_range(0, 128)) - 64;
            else
                z = int'($urandom_range(0, 128));
            if ($urandom_range(0, 1) == 1)
                z = -z;
            split_sum(z, a, b);
        end
    endtask

    // Field extremes, clipping both ways, tanh knee, bit patterns
    task automatic test_directed_corners();
        int dir_a [0:23] = '{0, 1, -1, 32767, -32768, 32767, -32768, 32767, -32768, 32767,
                             16384, -16384, 16383, -16383, 13709, -13709, 13000, 4096,
                             -4096, 21845, -21846, 0, 0, 2048};
        int dir_b [0:23] = '{0, 0, 0, 0, 0, 1, -1, 32767, -32768, -32768,
                             0, 0, 0, 0, 0, 0, 709, 0,
                             0, 0, 0, 21845, -21846, -4096};
        for (int i = 0; i < 24; i++)
            send_pair(DW'(dir_a[i]), DW'(dir_b[i]));
    endtask

    task automatic test_random_mix(input int count);
        logic signed [DW-1:0] a;
        logic signed [DW-1:0] b;
        for (int i = 0; i < count; i++)
        begin
            pick_random_pair(a, b);
            send_pair(a, b);
        end
    endtask

    // Bursts with the sender held off until the pipeline has emptied
    task automatic test_drain_pauses(input int rounds);
        logic signed [DW-1:0] a;
        logic signed [DW-1:0] b;
        for (int r = 0; r < rounds; r++)
        begin
            for (int i = 0; i < $urandom_range(1, 12); i++)
            begin
                pick_random_pair(a, b);
                send_pair(a, b);
            end
            wait_for_drain();
            drain_pauses++;
        end
    endtask

    // Full rate on both sides
    task automatic test_back_to_back(input int count);
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        test_random_mix(count);
    endtask

    // Receiver stalls in random bursts
    always @(posedge clk)
    begin
        if (sink_stall_left > 0)
        begin
            sink_stall_left--;
            out_ready <= 1'b0;
        end
        else if (sink_idle_en && $urandom_range(0, 5) == 0)
        begin
            sink_stall_left = $urandom_range(1, 11) - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Result checker, oldest expectation first
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_checked++;
            if (pending_gelu.size() == 0)
                note_failure($sformatf("result with nothing pending: gelu=%0d sat=%0b",
                                       gelu_value, sum_saturated));
            else
            begin
                head_res = pending_gelu.pop_front();
                if (head_res.sat)
                    sat_results++;
                if (gelu_value !== head_res.gelu || sum_saturated !== head_res.sat)
                    note_failure($sformatf(
                        "act=%0d bias=%0d: expected gelu=%0d sat=%0b, got gelu=%0d sat=%0b",
                        head_res.act, head_res.bias, head_res.gelu, head_res.sat,
                        gelu_value, sum_saturated));
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, pending_gelu.size());
        $display("Mismatches found");
        $finish;
    end

    initial
    begin
        fill_tanh_lut();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_corners();
        test_random_mix(1400);
        test_drain_pauses(10);
        test_back_to_back(300);

        wait_for_drain();
        repeat (2 * PIPE_DEPTH + 2) @(posedge clk);
        if (pending_gelu.size() != 0)
            note_failure($sformatf("%0d expected results never arrived", pending_gelu.size()));

        $display("covered %0d pairs (corners, tanh region, clipping, knee), %0d results checked",
                 items_sent, results_checked);
        $display("%0d clipped sums, %0d drain pauses, %0d failures",
                 sat_results, drain_pauses, fail_count);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
